// ===== hw/rtl/tfa_pkg.sv =====
// ----------------------------------------------------------------------------
// tfa_pkg: shared types, constants and decode functions
// Format, opcode and error codes, queue entry layout and channel widening
// tables for the texel format converter.
// ----------------------------------------------------------------------------
`default_nettype none

package tfa_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int MAX_TEXELS    = 262144;

	localparam int PAL_AW   = $clog2(PALETTE_DEPTH);
	localparam int PAL_N_W  = 9;
	localparam int TCOUNT_W = 19;
	localparam int CNT_W    = $clog2(MAX_TEXELS + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;

	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_FORMAT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_ENTRIES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXEL_COUNT     = 2'd2;

	typedef enum logic [2:0] {
		FMT_RGBA32   = 3'd0,
		FMT_RGBA4444 = 3'd1,
		FMT_IDX4     = 3'd2,
		FMT_IDX8     = 3'd3,
		FMT_RGB5A3   = 3'd4
	} fmt_t;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_CONVERT = 2'd1,
		OP_BEGIN   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK      = 2'd0,
		ERR_EMPTY   = 2'd1,
		ERR_RANGE   = 2'd2,
		ERR_SURPLUS = 2'd3
	} err_t;

	typedef struct packed {
		logic        is_write;
		fmt_t        fmt;
		logic [31:0] word;
		logic [7:0]  slot;
		logic        two;
		logic        last0;
		logic        done0;
		logic        done1;
		err_t        err0;
		err_t        err1;
	} work_t;

	function automatic logic [7:0] widen4(input logic [3:0] v);
		return {v, v};
	endfunction

	function automatic logic [7:0] widen3(input logic [2:0] v);
		logic [7:0] r;
		case (v)
			3'd0: r = 8'd0;
			3'd1: r = 8'd36;
			3'd2: r = 8'd73;
			3'd3: r = 8'd109;
			3'd4: r = 8'd146;
			3'd5: r = 8'd182;
			3'd6: r = 8'd219;
			default: r = 8'd255;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] widen5(input logic [4:0] v);
		logic [7:0] r;
		case (v)
			5'd0:  r = 8'd0;    5'd1:  r = 8'd8;    5'd2:  r = 8'd16;   5'd3:  r = 8'd25;
			5'd4:  r = 8'd33;   5'd5:  r = 8'd41;   5'd6:  r = 8'd49;   5'd7:  r = 8'd58;
			5'd8:  r = 8'd66;   5'd9:  r = 8'd74;   5'd10: r = 8'd82;   5'd11: r = 8'd90;
			5'd12: r = 8'd99;   5'd13: r = 8'd107;  5'd14: r = 8'd115;  5'd15: r = 8'd123;
			5'd16: r = 8'd132;  5'd17: r = 8'd140;  5'd18: r = 8'd148;  5'd19: r = 8'd156;
			5'd20: r = 8'd165;  5'd21: r = 8'd173;  5'd22: r = 8'd181;  5'd23: r = 8'd189;
			5'd24: r = 8'd197;  5'd25: r = 8'd206;  5'd26: r = 8'd214;  5'd27: r = 8'd222;
			5'd28: r = 8'd230;  5'd29: r = 8'd239;  5'd30: r = 8'd247;  default: r = 8'd255;
		endcase
		return r;
	endfunction

	// ABGR8888 from a non-indexed source word
	function automatic logic [31:0] decode_direct(input fmt_t fmt, input logic [31:0] w);
		logic [31:0] r;
		unique case (fmt)
			FMT_RGBA4444: r = {widen4(w[15:12]), widen4(w[11:8]), widen4(w[7:4]),
				widen4(w[3:0])};
			FMT_RGB5A3: begin
				if (w[15]) begin
					r = {8'hFF, widen5(w[4:0]), widen5(w[9:5]), widen5(w[14:10])};
				end else begin
					r = {widen3(w[14:12]), widen4(w[3:0]), widen4(w[7:4]), widen4(w[11:8])};
				end
			end
			default: r = w;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tfa_if.sv =====
// ----------------------------------------------------------------------------
// tfa_in_if / tfa_out_if: valid-ready channels
// Input item channel and result channel of the texel format converter.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfa_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] data_word;
	logic [7:0]  palette_slot;

	modport source (output valid, op, data_word, palette_slot, input ready);
	modport sink (input valid, op, data_word, palette_slot, output ready);
endinterface

interface tfa_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] texel;
	logic        last_of_run;
	logic        texture_done;
	logic [1:0]  error_code;

	modport source (output valid, texel, last_of_run, texture_done, error_code, input ready);
	modport sink (input valid, texel, last_of_run, texture_done, error_code, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tfa_front.sv =====
// ----------------------------------------------------------------------------
// tfa_front: item intake and classification
// Holds configuration and the texel counter, sorts items, flags surplus and
// palette errors, and queues palette writes and convert work.
// ----------------------------------------------------------------------------
`default_nettype none

module tfa_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tfa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tfa_pkg::CFG_DATA_W-1:0]     cfg_data,
	tfa_in_if.sink                             in_ch,
	input  logic                               q_full,
	output logic                               push,
	output tfa_pkg::work_t                     push_data
);

	tfa_pkg::fmt_t                   fmt_q;
	logic [tfa_pkg::PAL_N_W-1:0]     pal_n_q;
	logic [tfa_pkg::TCOUNT_W-1:0]    tcount_q;
	logic [tfa_pkg::CNT_W-1:0]       cnt_q;

	logic [tfa_pkg::CNT_W:0]         lim;
	logic [tfa_pkg::CNT_W:0]         cnt1;
	logic [tfa_pkg::CNT_W:0]         cnt2;
	logic [tfa_pkg::PAL_N_W-1:0]     pal_valid;
	logic [7:0]                      idx0;
	logic [7:0]                      idx1;
	logic                            surplus;
	logic                            is_idx;
	logic                            accept;
	tfa_pkg::work_t                  w;

	function automatic tfa_pkg::err_t pal_err(input logic [7:0] idx,
		input logic [tfa_pkg::PAL_N_W-1:0] n, input logic [tfa_pkg::PAL_N_W-1:0] nv);
		tfa_pkg::err_t e;
		if (n == '0) begin
			e = tfa_pkg::ERR_EMPTY;
		end else if ({1'b0, idx} >= nv) begin
			e = tfa_pkg::ERR_RANGE;
		end else begin
			e = tfa_pkg::ERR_OK;
		end
		return e;
	endfunction

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= tfa_pkg::FMT_RGBA32;
			pal_n_q  <= '0;
			tcount_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tfa_pkg::CFG_COLOR_FORMAT:    fmt_q <= tfa_pkg::fmt_t'(cfg_data[2:0]);
				tfa_pkg::CFG_PALETTE_ENTRIES: pal_n_q <= cfg_data[tfa_pkg::PAL_N_W-1:0];
				tfa_pkg::CFG_TEXEL_COUNT:     tcount_q <= cfg_data[tfa_pkg::TCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(tcount_q) > 32'(tfa_pkg::MAX_TEXELS)) begin
			lim = (tfa_pkg::CNT_W+1)'(tfa_pkg::MAX_TEXELS);
		end else begin
			lim = (tfa_pkg::CNT_W+1)'(tcount_q);
		end
		if (32'(pal_n_q) > 32'(tfa_pkg::PALETTE_DEPTH)) begin
			pal_valid = tfa_pkg::PAL_N_W'(tfa_pkg::PALETTE_DEPTH);
		end else begin
			pal_valid = pal_n_q;
		end
		cnt1    = {1'b0, cnt_q} + 1'b1;
		cnt2    = {1'b0, cnt_q} + 2'd2;
		surplus = {1'b0, cnt_q} >= lim;
		is_idx  = (fmt_q == tfa_pkg::FMT_IDX4) || (fmt_q == tfa_pkg::FMT_IDX8);
		idx0    = (fmt_q == tfa_pkg::FMT_IDX4) ? {4'b0, in_ch.data_word[3:0]}
			: in_ch.data_word[7:0];
		idx1    = {4'b0, in_ch.data_word[7:4]};

		w          = '0;
		w.is_write = (in_ch.op == tfa_pkg::OP_WRITE);
		w.fmt      = fmt_q;
		w.word     = in_ch.data_word;
		w.slot     = in_ch.palette_slot;
		if (surplus) begin
			w.last0 = 1'b1;
			w.err0  = tfa_pkg::ERR_SURPLUS;
		end else begin
			w.two   = (fmt_q == tfa_pkg::FMT_IDX4) && (cnt1 < lim);
			w.last0 = !w.two;
			w.done0 = w.two ? 1'b0 : (cnt1 == lim);
			w.done1 = (cnt2 == lim);
			if (is_idx) begin
				w.err0 = pal_err(idx0, pal_n_q, pal_valid);
				w.err1 = pal_err(idx1, pal_n_q, pal_valid);
			end
		end
		push_data = w;
		push      = accept && ((in_ch.op == tfa_pkg::OP_CONVERT) ||
			((in_ch.op == tfa_pkg::OP_WRITE) &&
			(32'(in_ch.palette_slot) < 32'(tfa_pkg::PALETTE_DEPTH))));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (in_ch.op == tfa_pkg::OP_BEGIN) begin
				cnt_q <= '0;
			end else if ((in_ch.op == tfa_pkg::OP_CONVERT) && !surplus) begin
				cnt_q <= w.two ? cnt2[tfa_pkg::CNT_W-1:0] : cnt1[tfa_pkg::CNT_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tfa_queue.sv =====
// ----------------------------------------------------------------------------
// tfa_queue: work queue
// Short first-in first-out buffer between the intake and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tfa_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tfa_pkg::work_t push_data,
	input  logic           pop,
	output tfa_pkg::work_t head,
	output logic           full,
	output logic           empty
);

	tfa_pkg::work_t                 buf_q [tfa_pkg::QUEUE_DEPTH];
	logic [tfa_pkg::QPTR_W-1:0]     wr_q;
	logic [tfa_pkg::QPTR_W-1:0]     rd_q;
	logic [tfa_pkg::QCNT_W-1:0]     cnt_q;

	assign full  = (cnt_q == tfa_pkg::QCNT_W'(tfa_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tfa_back.sv =====
// ----------------------------------------------------------------------------
// tfa_back: palette store and texel output
// Writes and reads the palette, decodes texels and issues one result per
// cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tfa_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  tfa_pkg::work_t head,
	output logic           pop,
	tfa_out_if.source      out_ch
);

	logic [31:0]                pal_q [tfa_pkg::PALETTE_DEPTH];

	logic                       valid_s1;
	logic                       phase_s1;
	tfa_pkg::work_t             work_s1;
	logic [31:0]                pd0_s1;
	logic [31:0]                pd1_s1;

	logic                       valid_s2;
	logic [31:0]                texel_s2;
	logic                       last_s2;
	logic                       done_s2;
	tfa_pkg::err_t              err_s2;

	logic                       s2_free;
	logic                       s1_final;
	logic                       s1_emit;
	logic                       s1_free;
	logic                       load_s1;
	logic [7:0]                 idx0;
	logic [7:0]                 idx1;
	logic [31:0]                texel;
	tfa_pkg::err_t              err;

	assign s2_free  = !valid_s2 || out_ch.ready;
	assign s1_final = phase_s1 || !work_s1.two;
	assign s1_emit  = valid_s1 && s2_free;
	assign s1_free  = !valid_s1 || (s1_emit && s1_final);
	assign pop      = !q_empty && (head.is_write || s1_free);
	assign load_s1  = pop && !head.is_write;
	assign idx0     = (head.fmt == tfa_pkg::FMT_IDX4) ? {4'b0, head.word[3:0]} : head.word[7:0];
	assign idx1     = {4'b0, head.word[7:4]};

	always_ff @(posedge clk) begin
		if (pop && head.is_write) begin
			pal_q[head.slot[tfa_pkg::PAL_AW-1:0]] <= head.word;
		end
		if (load_s1) begin
			work_s1 <= head;
			pd0_s1  <= pal_q[idx0[tfa_pkg::PAL_AW-1:0]];
			pd1_s1  <= pal_q[idx1[tfa_pkg::PAL_AW-1:0]];
		end
	end

	always_comb begin
		err = phase_s1 ? work_s1.err1 : work_s1.err0;
		case (work_s1.fmt)
			tfa_pkg::FMT_IDX8: texel = pd0_s1;
			tfa_pkg::FMT_IDX4: texel = phase_s1 ? pd1_s1 : pd0_s1;
			default:           texel = tfa_pkg::decode_direct(work_s1.fmt, work_s1.word);
		endcase
		if (err != tfa_pkg::ERR_OK) begin
			texel = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
				phase_s1 <= 1'b0;
			end else if (s1_emit && s1_final) begin
				valid_s1 <= 1'b0;
			end else if (s1_emit) begin
				phase_s1 <= 1'b1;
			end
			if (s1_emit) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_emit) begin
			texel_s2 <= texel;
			err_s2   <= err;
			last_s2  <= phase_s1 ? 1'b1 : work_s1.last0;
			done_s2  <= phase_s1 ? work_s1.done1 : work_s1.done0;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.texel        = texel_s2;
	assign out_ch.last_of_run  = last_s2;
	assign out_ch.texture_done = done_s2;
	assign out_ch.error_code   = err_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/texel_format_to_abgr8888.sv =====
// ----------------------------------------------------------------------------
// texel_format_to_abgr8888: texel format converter, top level
// Turns RGBA32, RGBA4444, indexed-4, indexed-8 and RGB5A3 data into
// ABGR8888 texels, with a loadable palette and a texel counter.
// ----------------------------------------------------------------------------
// One input item is taken per cycle while the four-entry work queue has room.
// Results leave through a registered output stage at one texel per cycle while
// the output is not stalled, so an indexed-4 item that yields two texels holds
// the output for both and sets the sustained rate for such data. A result
// passes through the work queue, the first stage and the output stage in order.
// Palette writes share the queue with convert items and reach the palette store
// in order, so a lookup always sees every write accepted before it. Palette
// writes, begin-texture and unused opcodes give no result.
`default_nettype none

module texel_format_to_abgr8888 (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tfa_pkg::CFG_DATA_W-1:0] cfg_data,
	tfa_in_if.sink                         in_ch,
	tfa_out_if.source                      out_ch
);

	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_empty;
	tfa_pkg::work_t push_data;
	tfa_pkg::work_t head;

	tfa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	tfa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	tfa_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/tfa_checker.sv =====
// ----------------------------------------------------------------------------
// tfa_checker: port-level checks
// Watches the result channel of the texel format converter.
// ----------------------------------------------------------------------------
`default_nettype none

module tfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] texel,
	input logic        last_of_run,
	input logic        texture_done,
	input logic [1:0]  error_code
);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code != tfa_pkg::ERR_OK) |-> (texel == 32'd0))
		else $error("texel not zero on error");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && texture_done |-> last_of_run)
		else $error("texture_done without last_of_run");

	a_surplus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code == tfa_pkg::ERR_SURPLUS) |-> !texture_done && last_of_run)
		else $error("surplus result flags wrong");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(texel) && $stable(error_code))
		else $error("stalled result changed");

endmodule

bind texel_format_to_abgr8888 tfa_checker u_tfa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.texel        (out_ch.texel),
	.last_of_run  (out_ch.last_of_run),
	.texture_done (out_ch.texture_done),
	.error_code   (out_ch.error_code)
);

`default_nettype wire
